// ===== rtl/polar_phasor_arithmetic_core_assert.svh =====
// Assertion macros for the phasor arithmetic RTL.
`ifndef POLAR_PHASOR_ARITHMETIC_CORE_ASSERT_SVH
`define POLAR_PHASOR_ARITHMETIC_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppa_pkg.sv =====
// Types, constants and helper functions of the polar phasor arithmetic core.
`default_nettype none

package ppa_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int MAG_W     = 24;
    localparam int ANG_W     = 16;
    localparam int MAG_FRAC  = 8;
    localparam int ANG_FRAC  = 7;
    localparam int ANGX_W    = ANG_W + 1;
    localparam int WRAP_W    = ANG_W + 3;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int WIDE_W    = PROD_W - MAG_FRAC;

    // Angle constants in output units
    localparam int ANG_HALF    = 180 << ANG_FRAC;
    localparam int ANG_FULL    = 2 * ANG_HALF;
    localparam int ANG_QUARTER = 90 << ANG_FRAC;

    // CORDIC formats: components Q.16 signed, angles in 2^-20 degree
    localparam int ZU        = 20;
    localparam int ZSH       = ZU - ANG_FRAC;
    localparam int CW        = 36;
    localparam int ZW        = 30;
    localparam int ADD_MAG_W = 28;
    localparam int TAB_LEN   = 24;
    localparam int unsigned DEF_CORDIC_STAGES = 16;
    localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;

    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [CW-1:0]     comp_t;
    typedef logic signed [ZW-1:0]     zang_t;

    localparam zang_t Z_HALF = zang_t'(180 << ZU);
    localparam zang_t Z_RND  = zang_t'(1 << (ZSH - 1));

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2
    } kind_t;

    // One CORDIC stage: both components and the residual angle
    typedef struct packed {
        comp_t x;
        comp_t y;
        zang_t z;
    } cstate_t;

    // Wrap an angle within one turn of the range into (-180,180]
    function automatic ang_t wrap_ang(input logic signed [WRAP_W-1:0] v);
        logic signed [WRAP_W-1:0] r;
        if (v > WRAP_W'(ANG_HALF))
            r = v - WRAP_W'(ANG_FULL);
        else if (v <= -WRAP_W'(ANG_HALF))
            r = v + WRAP_W'(ANG_FULL);
        else
            r = v;
        return ANG_W'(r);
    endfunction

    // atan(2^-i) in 2^-20 degree, rounded
    function automatic zang_t atan_entry(input int unsigned i);
        case (i)
            0:       return zang_t'(47185920);
            1:       return zang_t'(27855475);
            2:       return zang_t'(14718068);
            3:       return zang_t'(7471121);
            4:       return zang_t'(3750058);
            5:       return zang_t'(1876857);
            6:       return zang_t'(938658);
            7:       return zang_t'(469357);
            8:       return zang_t'(234682);
            9:       return zang_t'(117342);
            10:      return zang_t'(58671);
            11:      return zang_t'(29335);
            12:      return zang_t'(14668);
            13:      return zang_t'(7334);
            14:      return zang_t'(3667);
            15:      return zang_t'(1833);
            16:      return zang_t'(917);
            17:      return zang_t'(458);
            18:      return zang_t'(229);
            19:      return zang_t'(115);
            20:      return zang_t'(57);
            21:      return zang_t'(29);
            22:      return zang_t'(14);
            23:      return zang_t'(7);
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ppa_req_if.sv =====
// Request channel: operation code and two polar phasors.
`default_nettype none

interface ppa_req_if import ppa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    mag_t              mag_a;
    ang_t              ang_a;
    mag_t              mag_b;
    ang_t              ang_b;

    modport source (output valid, kind, mag_a, ang_a, mag_b, ang_b, input ready);
    modport sink   (input valid, kind, mag_a, ang_a, mag_b, ang_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppa_rsp_if.sv =====
// Response channel: result phasor and status flags.
`default_nettype none

interface ppa_rsp_if import ppa_pkg::*; ();
    logic valid;
    logic ready;
    mag_t mag_out;
    ang_t ang_out;
    logic saturated;
    logic div_by_zero;

    modport source (output valid, mag_out, ang_out, saturated, div_by_zero, input ready);
    modport sink   (input valid, mag_out, ang_out, saturated, div_by_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppa_div.sv =====
// Pipelined restoring divider for the magnitude quotient, one bit per stage.
`default_nettype none

module ppa_div import ppa_pkg::*; #(
    parameter int unsigned LATENCY = MAG_W + 1
) (
    input  wire  clk,
    input  wire  en,
    input  mag_t mag_a,
    input  mag_t mag_b,
    output mag_t quo,
    output logic sat
);

    localparam int unsigned CORE   = MAG_W + 1;
    localparam int unsigned PAD    = LATENCY - CORE;
    localparam int          DIVN_W = MAG_W + MAG_FRAC + 1;

    typedef struct packed {
        mag_t rem;
        mag_t low;
        mag_t quo;
        mag_t den;
        logic sat;
    } dstage_t;

    typedef struct packed {
        mag_t quo;
        logic sat;
    } dres_t;

    logic [DIVN_W-1:0] num;
    dstage_t           d0_reg;
    dstage_t           st_in  [MAG_W];
    dstage_t           st_reg [MAG_W];
    dres_t             core_res;

    // Rounded dividend; the quotient overflows when its top part reaches the divisor
    assign num = {1'b0, mag_a, {MAG_FRAC{1'b0}}} + DIVN_W'(mag_b >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg.rem <= MAG_W'(num[DIVN_W-1:MAG_W]);
            d0_reg.low <= num[MAG_W-1:0];
            d0_reg.quo <= '0;
            d0_reg.den <= mag_b;
            d0_reg.sat <= MAG_W'(num[DIVN_W-1:MAG_W]) >= mag_b;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < MAG_W; k++)
    begin : g_step
        logic [MAG_W:0] trial;
        logic           take;

        if (k == 0)
        begin : g_first
            assign st_in[k] = d0_reg;
        end
        else
        begin : g_next
            assign st_in[k] = st_reg[k-1];
        end

        assign trial = {st_in[k].rem, st_in[k].low[MAG_W-1-k]};
        assign take  = trial >= {1'b0, st_in[k].den};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k].rem <= take ? MAG_W'(trial - {1'b0, st_in[k].den})
                                      : MAG_W'(trial);
                st_reg[k].low <= st_in[k].low;
                st_reg[k].quo <= {st_in[k].quo[MAG_W-2:0], take};
                st_reg[k].den <= st_in[k].den;
                st_reg[k].sat <= st_in[k].sat;
            end
        end
    end

    assign core_res.quo = st_reg[MAG_W-1].quo;
    assign core_res.sat = st_reg[MAG_W-1].sat;

    // Delay to the common pipeline depth
    if (PAD > 0)
    begin : g_pad
        dres_t pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= core_res;
                for (int p = 1; p < int'(PAD); p++)
                    pad_reg[p] <= pad_reg[p-1];
            end
        end

        assign quo = pad_reg[PAD-1].quo;
        assign sat = pad_reg[PAD-1].sat;
    end
    else
    begin : g_nopad
        assign quo = core_res.quo;
        assign sat = core_res.sat;
    end

endmodule

`default_nettype wire

// ===== rtl/ppa_cordic.sv =====
// Polar add path: two CORDIC rotation lanes, rectangular sum, CORDIC vectoring.
`default_nettype none

module ppa_cordic import ppa_pkg::*; #(
    parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int unsigned LATENCY       = 2 * DEF_CORDIC_STAGES + 6
) (
    input  wire                   clk,
    input  wire                   en,
    input  mag_t                  mag_a,
    input  mag_t                  mag_b,
    input  ang_t                  ang_a,
    input  ang_t                  ang_b,
    output logic [ADD_MAG_W-1:0]  mag,
    output ang_t                  ang,
    output logic                  zero
);

    localparam int unsigned CORE = 2 * CORDIC_STAGES + 6;
    localparam int unsigned PAD  = LATENCY - CORE;
    localparam int          N    = int'(CORDIC_STAGES);
    localparam int          VX_W = CW - 1;
    localparam int          HI_W = VX_W - 16 + 32;
    localparam int          LO_W = 48;
    localparam int          RS_W = HI_W - 16;
    localparam logic [63:0] RND64 = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [31:0] x0;
        logic        neg;
        zang_t       z;
    } pre_t;

    typedef struct packed {
        logic [ADD_MAG_W-1:0] mag;
        ang_t                 ang;
        logic                 zero;
    } cres_t;

    mag_t    mag_in  [2];
    ang_t    ang_in  [2];
    pre_t    pre_reg [2];
    cstate_t rot_in  [2][N];
    cstate_t rot_reg [2][N];

    comp_t   sum_x_reg;
    comp_t   sum_y_reg;
    cstate_t vp_reg;
    logic    vzero_reg;
    cstate_t vec_in  [N];
    cstate_t vec_reg [N];
    logic [N-1:0] vz_reg;

    logic [VX_W-1:0]   vx;
    logic [LO_W-1:0]   lo_prod;
    zang_t             z_rnd;
    logic [HI_W-1:0]   m1_hi_reg;
    logic [31:0]       m1_lo_reg;
    logic [ANGX_W-1:0] m1_ang_reg;
    logic              m1_zero_reg;
    logic [HI_W-1:0]   m2_sum_reg;
    ang_t              m2_ang_reg;
    logic              m2_zero_reg;
    logic [RS_W-1:0]   rnd_sum;
    cres_t             m3_reg;

    assign mag_in[0] = mag_a;
    assign mag_in[1] = mag_b;
    assign ang_in[0] = ang_a;
    assign ang_in[1] = ang_b;

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [63:0]       scaled;
        logic signed [ANGX_W-1:0] zq;
        logic              neg;

        // Gain compensation and fold into the right half plane
        always_comb
        begin
            scaled = 64'({mag_in[l], {MAG_FRAC{1'b0}}}) * 64'(INV_GAIN) + RND64;
            if (ang_in[l] > ANG_W'(ANG_QUARTER))
            begin
                neg = 1'b1;
                zq  = ANGX_W'(ang_in[l]) - ANGX_W'(ANG_HALF);
            end
            else if (ang_in[l] < -ANG_W'(ANG_QUARTER))
            begin
                neg = 1'b1;
                zq  = ANGX_W'(ang_in[l]) + ANGX_W'(ANG_HALF);
            end
            else
            begin
                neg = 1'b0;
                zq  = ANGX_W'(ang_in[l]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pre_reg[l].x0  <= scaled[63:32];
                pre_reg[l].neg <= neg;
                pre_reg[l].z   <= ZW'(zq) <<< ZSH;
            end
        end

        // Rotation stages
        for (genvar i = 0; i < N; i++)
        begin : g_rot
            localparam zang_t ATAN_I = atan_entry(i);

            if (i == 0)
            begin : g_first
                assign rot_in[l][i].x = pre_reg[l].neg ? -comp_t'(pre_reg[l].x0)
                                                       : comp_t'(pre_reg[l].x0);
                assign rot_in[l][i].y = '0;
                assign rot_in[l][i].z = pre_reg[l].z;
            end
            else
            begin : g_next
                assign rot_in[l][i] = rot_reg[l][i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rot_in[l][i].z >= 0)
                    begin
                        rot_reg[l][i].x <= rot_in[l][i].x - (rot_in[l][i].y >>> i);
                        rot_reg[l][i].y <= rot_in[l][i].y + (rot_in[l][i].x >>> i);
                        rot_reg[l][i].z <= rot_in[l][i].z - ATAN_I;
                    end
                    else
                    begin
                        rot_reg[l][i].x <= rot_in[l][i].x + (rot_in[l][i].y >>> i);
                        rot_reg[l][i].y <= rot_in[l][i].y - (rot_in[l][i].x >>> i);
                        rot_reg[l][i].z <= rot_in[l][i].z + ATAN_I;
                    end
                end
            end
        end
    end

    // Rectangular sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg <= rot_reg[0][N-1].x + rot_reg[1][N-1].x;
            sum_y_reg <= rot_reg[0][N-1].y + rot_reg[1][N-1].y;
        end
    end

    // Fold the left half plane over before vectoring
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vzero_reg <= (sum_x_reg == '0) && (sum_y_reg == '0);
            if (sum_x_reg < 0)
            begin
                vp_reg.x <= -sum_x_reg;
                vp_reg.y <= -sum_y_reg;
                vp_reg.z <= (sum_y_reg >= 0) ? Z_HALF : -Z_HALF;
            end
            else
            begin
                vp_reg.x <= sum_x_reg;
                vp_reg.y <= sum_y_reg;
                vp_reg.z <= '0;
            end
        end
    end

    // Vectoring stages
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam zang_t ATAN_I = atan_entry(i);

        if (i == 0)
        begin : g_first
            assign vec_in[i] = vp_reg;
        end
        else
        begin : g_next
            assign vec_in[i] = vec_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vec_in[i].y >= 0)
                begin
                    vec_reg[i].x <= vec_in[i].x + (vec_in[i].y >>> i);
                    vec_reg[i].y <= vec_in[i].y - (vec_in[i].x >>> i);
                    vec_reg[i].z <= vec_in[i].z + ATAN_I;
                end
                else
                begin
                    vec_reg[i].x <= vec_in[i].x - (vec_in[i].y >>> i);
                    vec_reg[i].y <= vec_in[i].y + (vec_in[i].x >>> i);
                    vec_reg[i].z <= vec_in[i].z - ATAN_I;
                end
            end
        end
    end

    // Zero-sum flag rides alongside the vectoring stages
    always_ff @(posedge clk)
    begin
        if (en)
            vz_reg <= {vz_reg[N-2:0], vzero_reg};
    end

    // Length scaling split into two partial products; angle rounding
    assign vx      = vec_reg[N-1].x[VX_W-1:0];
    assign lo_prod = LO_W'(vx[15:0]) * LO_W'(INV_GAIN) + LO_W'(RND64);
    assign z_rnd   = vec_reg[N-1].z + Z_RND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_hi_reg   <= HI_W'(vx[VX_W-1:16]) * HI_W'(INV_GAIN);
            m1_lo_reg   <= lo_prod[LO_W-1:16];
            m1_ang_reg  <= ANGX_W'(z_rnd >>> ZSH);
            m1_zero_reg <= vz_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_sum_reg  <= m1_hi_reg + HI_W'(m1_lo_reg);
            m2_ang_reg  <= wrap_ang(WRAP_W'(signed'(m1_ang_reg)));
            m2_zero_reg <= m1_zero_reg;
        end
    end

    // Round length to Q20.8
    assign rnd_sum = m2_sum_reg[HI_W-1:16] + RS_W'(1 << (MAG_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg.mag  <= ADD_MAG_W'(rnd_sum >> MAG_FRAC);
            m3_reg.ang  <= m2_ang_reg;
            m3_reg.zero <= m2_zero_reg;
        end
    end

    // Delay to the common pipeline depth
    if (PAD > 0)
    begin : g_pad
        cres_t pad_reg [PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= m3_reg;
                for (int p = 1; p < int'(PAD); p++)
                    pad_reg[p] <= pad_reg[p-1];
            end
        end

        assign mag  = pad_reg[PAD-1].mag;
        assign ang  = pad_reg[PAD-1].ang;
        assign zero = pad_reg[PAD-1].zero;
    end
    else
    begin : g_nopad
        assign mag  = m3_reg.mag;
        assign ang  = m3_reg.ang;
        assign zero = m3_reg.zero;
    end

endmodule

`default_nettype wire

// ===== rtl/polar_phasor_arithmetic_core.sv =====
// Top level of the polar phasor arithmetic core.
`default_nettype none
`include "polar_phasor_arithmetic_core_assert.svh"

// Polar phasor add, multiply and divide. Fully pipelined: one request is
// taken every cycle while no result waits untaken. The depth LAT is the
// larger of the add path depth and the divider depth; at the default of 16
// CORDIC stages it is set by the add path (two CORDIC rotation lanes, a
// rectangular sum and a CORDIC vectoring chain), and the magnitude divider
// runs beside it one quotient bit per stage. All stages advance together, so
// a stalled response holds the whole pipeline and requests stay in order. On
// overflow every operation saturates the magnitude to all ones and sets
// saturated; divide by a zero magnitude returns all ones with div_by_zero set.
module polar_phasor_arithmetic_core import ppa_pkg::*; #(
    parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input wire         clk,
    input wire         rst_n,
    ppa_req_if.sink    req,
    ppa_rsp_if.source  rsp
);

    localparam int unsigned CORD_LAT = 2 * CORDIC_STAGES + 6;
    localparam int unsigned DIV_LAT  = MAG_W + 1;
    localparam int unsigned LAT      = (CORD_LAT > DIV_LAT) ? CORD_LAT : DIV_LAT;
    localparam mag_t        MAG_MAX  = '1;

    // Fields that bypass the CORDIC and divider units
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              eq;
        logic              mb_zero;
        ang_t              wa;
        ang_t              ang_md;
        logic [PROD_W-1:0] prod;
        logic [MAG_W:0]    sum_eq;
    } side_t;

    logic                 en;
    logic [LAT:0]         vld_reg;
    side_t                side_reg;
    side_t                side_pipe_reg [LAT];
    mag_t                 mag_a_reg;
    mag_t                 mag_b_reg;
    ang_t                 wb_reg;
    logic                 out_valid_reg;
    mag_t                 mag_out_reg;
    ang_t                 ang_out_reg;
    logic                 sat_out_reg;
    logic                 dz_out_reg;

    logic [WRAP_W-1:0]    ang_raw_md;
    logic [ADD_MAG_W-1:0] cor_mag;
    ang_t                 cor_ang;
    logic                 cor_zero;
    mag_t                 div_quo;
    logic                 div_sat;

    side_t                side_last;
    logic [WIDE_W-1:0]    mag_wide;
    ang_t                 ang_next;
    logic                 dz_next;
    logic                 sat_next;
    mag_t                 mag_next;

    // Whole pipeline moves unless a result is waiting and not taken
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-1:0], req.valid};
            out_valid_reg <= vld_reg[LAT];
        end
    end

    // Front stage: wrap angles, magnitude product, sideband
    assign ang_raw_md = (kind_t'(req.kind) == KIND_DIV)
                      ? WRAP_W'(req.ang_a) - WRAP_W'(req.ang_b)
                      : WRAP_W'(req.ang_a) + WRAP_W'(req.ang_b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg.kind    <= req.kind;
            side_reg.eq      <= req.ang_a == req.ang_b;
            side_reg.mb_zero <= req.mag_b == '0;
            side_reg.wa      <= wrap_ang(WRAP_W'(req.ang_a));
            side_reg.ang_md  <= wrap_ang(ang_raw_md);
            side_reg.prod    <= PROD_W'(req.mag_a) * PROD_W'(req.mag_b);
            side_reg.sum_eq  <= (MAG_W + 1)'(req.mag_a) + (MAG_W + 1)'(req.mag_b);
            mag_a_reg        <= req.mag_a;
            mag_b_reg        <= req.mag_b;
            wb_reg           <= wrap_ang(WRAP_W'(req.ang_b));
        end
    end

    // Sideband delay matching the unit depth
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side_reg;
            for (int p = 1; p < int'(LAT); p++)
                side_pipe_reg[p] <= side_pipe_reg[p-1];
        end
    end

    ppa_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .LATENCY       (LAT)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .ang_a (side_reg.wa),
        .ang_b (wb_reg),
        .mag   (cor_mag),
        .ang   (cor_ang),
        .zero  (cor_zero)
    );

    ppa_div #(
        .LATENCY (LAT)
    ) u_div (
        .clk   (clk),
        .en    (en),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    // Result select and saturation
    assign side_last = side_pipe_reg[LAT-1];

    always_comb
    begin
        mag_wide = '0;
        ang_next = '0;
        dz_next  = 1'b0;
        case (kind_t'(side_last.kind))
            KIND_ADD:
            begin
                if (side_last.eq)
                begin
                    mag_wide = WIDE_W'(side_last.sum_eq);
                    ang_next = side_last.wa;
                end
                else if (!cor_zero)
                begin
                    mag_wide = WIDE_W'(cor_mag);
                    ang_next = cor_ang;
                end
            end
            KIND_MUL:
            begin
                mag_wide = WIDE_W'((side_last.prod + PROD_W'(1 << (MAG_FRAC - 1)))
                                   >> MAG_FRAC);
                ang_next = side_last.ang_md;
            end
            KIND_DIV:
            begin
                ang_next = side_last.ang_md;
                if (side_last.mb_zero)
                begin
                    mag_wide = WIDE_W'(MAG_MAX);
                    dz_next  = 1'b1;
                end
                else if (div_sat)
                    mag_wide = WIDE_W'(1) << MAG_W;
                else
                    mag_wide = WIDE_W'(div_quo);
            end
            default:
            begin
                mag_wide = '0;
                ang_next = '0;
            end
        endcase
        sat_next = mag_wide > WIDE_W'(MAG_MAX);
        mag_next = sat_next ? MAG_MAX : mag_wide[MAG_W-1:0];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_out_reg <= mag_next;
            ang_out_reg <= ang_next;
            sat_out_reg <= sat_next;
            dz_out_reg  <= dz_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.mag_out     = mag_out_reg;
    assign rsp.ang_out     = ang_out_reg;
    assign rsp.saturated   = sat_out_reg;
    assign rsp.div_by_zero = dz_out_reg;

    // Checks
    `PPA_ASSERT_IMP(a_dz_full_scale, rsp.valid && rsp.div_by_zero,
        (&rsp.mag_out) && !rsp.saturated, "divide by zero without full-scale magnitude")
    `PPA_ASSERT_IMP(a_sat_full_scale, rsp.valid && rsp.saturated, &rsp.mag_out,
        "saturated result not clipped to full scale")
    `PPA_ASSERT_IMP(a_ang_range, rsp.valid,
        (rsp.ang_out > -ANG_W'(ANG_HALF)) && (rsp.ang_out <= ANG_W'(ANG_HALF)),
        "result angle outside half-open turn")
    `PPA_ASSERT_NXT(a_stall_holds, !en, $stable(vld_reg) && $stable(out_valid_reg),
        "pipeline valid bits moved during a stall")

endmodule

`default_nettype wire
